### src/segment_intersection_test_macros.svh
// Assertion macros shared by the segment intersection test RTL.
`ifndef SEGMENT_INTERSECTION_TEST_MACROS_SVH
`define SEGMENT_INTERSECTION_TEST_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define SIT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define SIT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/sit_pkg.sv
// Types and constants for the segment intersection test.
`default_nettype none
package sit_pkg;

  localparam int COORD_BITS = 16;
  localparam int EPS_W      = 15;
  localparam int EPS_FRAC   = 16;
  localparam int AD_W       = 32;  // magnitude of the determinant
  localparam int AN_W       = 33;  // magnitude of a numerator
  localparam int QBITS      = 31;  // quotient bits below the saturation point
  localparam int PARALLEL_PARAM = -100;
  localparam logic [31:0] SAT_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] SAT_MIN = 32'h8000_0000;
  localparam logic [EPS_W-1:0] EPS_RESET = 15'd66;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] first_start_x;
    logic signed [COORD_BITS-1:0] first_start_y;
    logic signed [COORD_BITS-1:0] first_dir_x;
    logic signed [COORD_BITS-1:0] first_dir_y;
    logic signed [COORD_BITS-1:0] second_start_x;
    logic signed [COORD_BITS-1:0] second_start_y;
    logic signed [COORD_BITS-1:0] second_dir_x;
    logic signed [COORD_BITS-1:0] second_dir_y;
    logic                         count_endpoints;
  } sit_in_t;

  typedef struct packed {
    logic               hit;
    logic               is_parallel;
    logic signed [31:0] param_first;
    logic signed [31:0] param_second;
  } sit_out_t;

  // Decision bits that ride alongside the divider.
  typedef struct packed {
    logic hit;
    logic par;
    logic neg1;
    logic neg2;
    logic sat1;
    logic sat2;
  } sit_meta_t;

endpackage
`default_nettype wire

### src/sit_front.sv
// Front pipeline: offsets, cross products, magnitudes and exact hit window test.
`default_nettype none
module sit_front #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  input  wire sit_pkg::sit_in_t              operands,
  input  wire logic [sit_pkg::EPS_W-1:0]     eps,
  output logic                               out_valid,
  output sit_pkg::sit_meta_t                 out_meta,
  output logic [sit_pkg::AD_W-1:0]           out_ad,
  output logic [sit_pkg::AD_W-1:0]           out_r1,
  output logic [sit_pkg::QBITS-1:0]          out_low1,
  output logic [sit_pkg::AD_W-1:0]           out_r2,
  output logic [sit_pkg::QBITS-1:0]          out_low2
);
  import sit_pkg::*;

  localparam int NW = AN_W + FRAC_BITS;
  localparam int RW = NW - QBITS;
  localparam int SW = AN_W + EPS_FRAC;

  logic [6:0] vld;

  // stage 1
  sit_in_t op1;
  // stage 2
  logic signed [COORD_BITS:0]   ox2, oy2;
  logic signed [COORD_BITS-1:0] d1x2, d1y2, d2x2, d2y2;
  logic                         cl2;
  // stage 3
  logic signed [2*COORD_BITS-1:0] pa3, pb3;
  logic signed [2*COORD_BITS:0]   pc3, pd3, pe3, pf3;
  logic                           cl3;
  // stage 4
  logic signed [2*COORD_BITS:0]   det4;
  logic signed [2*COORD_BITS+1:0] n1_4, n2_4;
  logic                           cl4;
  // stage 5
  logic [AD_W-1:0] ad5;
  logic [AN_W-1:0] an1_5, an2_5;
  logic            neg1_5, neg2_5, ok1_5, ok2_5, par5, cl5;
  // stage 6
  logic [AD_W-1:0]     ad6, r1_6, r2_6;
  logic [QBITS-1:0]    low1_6, low2_6;
  logic [AN_W-1:0]     an1_6, an2_6;
  logic [SW-1:0]       lo6, hi6;
  logic                neg1_6, neg2_6, ok1_6, ok2_6, par6, cl6, sat1_6, sat2_6;

  logic [2*COORD_BITS:0]   det_mag;
  logic [2*COORD_BITS+1:0] n1_mag, n2_mag;
  logic                    neg1_c, neg2_c;
  logic [NW-1:0]           nfull1, nfull2;
  logic [RW-1:0]           rinit1, rinit2;
  logic [EPS_FRAC:0]       top;
  logic [SW-1:0]           sc1, sc2;
  logic                    win1, win2;

  always_comb begin
    det_mag = det4[2*COORD_BITS] ? -det4 : det4;
    n1_mag  = n1_4[2*COORD_BITS+1] ? -n1_4 : n1_4;
    n2_mag  = n2_4[2*COORD_BITS+1] ? -n2_4 : n2_4;
    neg1_c  = (n1_4 != '0) && (n1_4[2*COORD_BITS+1] != det4[2*COORD_BITS]);
    neg2_c  = (n2_4 != '0) && (n2_4[2*COORD_BITS+1] != det4[2*COORD_BITS]);
    nfull1  = {an1_5, {FRAC_BITS{1'b0}}};
    nfull2  = {an2_5, {FRAC_BITS{1'b0}}};
    rinit1  = nfull1[NW-1:QBITS];
    rinit2  = nfull2[NW-1:QBITS];
    top     = (EPS_FRAC+1)'(1 << EPS_FRAC) - (EPS_FRAC+1)'(eps);
    sc1     = {an1_6, {EPS_FRAC{1'b0}}};
    sc2     = {an2_6, {EPS_FRAC{1'b0}}};
    win1    = (sc1 >= lo6) && (sc1 <= hi6);
    win2    = (sc2 >= lo6) && (sc2 <= hi6);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[5:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    op1 <= operands;

    ox2  <= {op1.second_start_x[COORD_BITS-1], op1.second_start_x}
          - {op1.first_start_x[COORD_BITS-1], op1.first_start_x};
    oy2  <= {op1.second_start_y[COORD_BITS-1], op1.second_start_y}
          - {op1.first_start_y[COORD_BITS-1], op1.first_start_y};
    d1x2 <= op1.first_dir_x;
    d1y2 <= op1.first_dir_y;
    d2x2 <= op1.second_dir_x;
    d2y2 <= op1.second_dir_y;
    cl2  <= op1.count_endpoints;

    pa3 <= d2x2 * d1y2;
    pb3 <= d2y2 * d1x2;
    pc3 <= d2x2 * oy2;
    pd3 <= d2y2 * ox2;
    pe3 <= d1x2 * oy2;
    pf3 <= d1y2 * ox2;
    cl3 <= cl2;

    det4 <= {pa3[2*COORD_BITS-1], pa3} - {pb3[2*COORD_BITS-1], pb3};
    n1_4 <= {pc3[2*COORD_BITS], pc3} - {pd3[2*COORD_BITS], pd3};
    n2_4 <= {pe3[2*COORD_BITS], pe3} - {pf3[2*COORD_BITS], pf3};
    cl4  <= cl3;

    ad5    <= det_mag[AD_W-1:0];
    an1_5  <= n1_mag[AN_W-1:0];
    an2_5  <= n2_mag[AN_W-1:0];
    neg1_5 <= neg1_c;
    neg2_5 <= neg2_c;
    ok1_5  <= !neg1_c && (n1_mag <= (2*COORD_BITS+2)'(det_mag));
    ok2_5  <= !neg2_c && (n2_mag <= (2*COORD_BITS+2)'(det_mag));
    par5   <= (det4 == '0);
    cl5    <= cl4;

    ad6    <= ad5;
    an1_6  <= an1_5;
    an2_6  <= an2_5;
    lo6    <= SW'(eps) * SW'(ad5);
    hi6    <= SW'(top) * SW'(ad5);
    r1_6   <= AD_W'(rinit1);
    r2_6   <= AD_W'(rinit2);
    low1_6 <= nfull1[QBITS-1:0];
    low2_6 <= nfull2[QBITS-1:0];
    sat1_6 <= AD_W'(rinit1) >= ad5;
    sat2_6 <= AD_W'(rinit2) >= ad5;
    neg1_6 <= neg1_5;
    neg2_6 <= neg2_5;
    ok1_6  <= ok1_5;
    ok2_6  <= ok2_5;
    par6   <= par5;
    cl6    <= cl5;

    out_meta.hit  <= ok1_6 && ok2_6 && (cl6 || (win1 && win2));
    out_meta.par  <= par6;
    out_meta.neg1 <= neg1_6;
    out_meta.neg2 <= neg2_6;
    out_meta.sat1 <= sat1_6;
    out_meta.sat2 <= sat2_6;
    out_ad        <= ad6;
    out_r1        <= r1_6;
    out_r2        <= r2_6;
    out_low1      <= low1_6;
    out_low2      <= low2_6;
  end

  assign out_valid = vld[6];

endmodule
`default_nettype wire

### src/sit_div.sv
// Restoring divider pipeline, one quotient bit per stage for two numerators.
`default_nettype none
module sit_div (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      in_valid,
  input  wire sit_pkg::sit_meta_t        in_meta,
  input  wire logic [sit_pkg::AD_W-1:0]  in_ad,
  input  wire logic [sit_pkg::AD_W-1:0]  in_r1,
  input  wire logic [sit_pkg::QBITS-1:0] in_low1,
  input  wire logic [sit_pkg::AD_W-1:0]  in_r2,
  input  wire logic [sit_pkg::QBITS-1:0] in_low2,
  output logic                           out_valid,
  output sit_pkg::sit_meta_t             out_meta,
  output logic [sit_pkg::QBITS-1:0]      out_q1,
  output logic [sit_pkg::QBITS-1:0]      out_q2
);
  import sit_pkg::*;

  logic             vld  [0:QBITS-1];
  sit_meta_t        meta [0:QBITS-1];
  logic [AD_W-1:0]  ad   [0:QBITS-1];
  logic [AD_W-1:0]  rem1 [0:QBITS-1];
  logic [AD_W-1:0]  rem2 [0:QBITS-1];
  logic [QBITS-1:0] low1 [0:QBITS-1];
  logic [QBITS-1:0] low2 [0:QBITS-1];
  logic [QBITS-1:0] q1   [0:QBITS-1];
  logic [QBITS-1:0] q2   [0:QBITS-1];

  for (genvar k = 0; k < QBITS; k++) begin : g_stage
    logic             s_vld;
    sit_meta_t        s_meta;
    logic [AD_W-1:0]  s_ad, s_rem1, s_rem2;
    logic [QBITS-1:0] s_low1, s_low2, s_q1, s_q2;
    logic [AD_W:0]    sh1, sh2, df1, df2;
    logic             ge1, ge2;

    if (k == 0) begin : g_src
      assign s_vld  = in_valid;
      assign s_meta = in_meta;
      assign s_ad   = in_ad;
      assign s_rem1 = in_r1;
      assign s_rem2 = in_r2;
      assign s_low1 = in_low1;
      assign s_low2 = in_low2;
      assign s_q1   = '0;
      assign s_q2   = '0;
    end else begin : g_src
      assign s_vld  = vld[k-1];
      assign s_meta = meta[k-1];
      assign s_ad   = ad[k-1];
      assign s_rem1 = rem1[k-1];
      assign s_rem2 = rem2[k-1];
      assign s_low1 = low1[k-1];
      assign s_low2 = low2[k-1];
      assign s_q1   = q1[k-1];
      assign s_q2   = q2[k-1];
    end

    // Bring down the next dividend bit, subtract when it fits.
    always_comb begin
      sh1 = {s_rem1, s_low1[QBITS-1-k]};
      sh2 = {s_rem2, s_low2[QBITS-1-k]};
      df1 = sh1 - {1'b0, s_ad};
      df2 = sh2 - {1'b0, s_ad};
      ge1 = sh1 >= {1'b0, s_ad};
      ge2 = sh2 >= {1'b0, s_ad};
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else begin
        vld[k] <= s_vld;
      end
    end

    always_ff @(posedge clk) begin
      meta[k] <= s_meta;
      ad[k]   <= s_ad;
      low1[k] <= s_low1;
      low2[k] <= s_low2;
      rem1[k] <= ge1 ? df1[AD_W-1:0] : sh1[AD_W-1:0];
      rem2[k] <= ge2 ? df2[AD_W-1:0] : sh2[AD_W-1:0];
      q1[k]   <= {s_q1[QBITS-2:0], ge1};
      q2[k]   <= {s_q2[QBITS-2:0], ge2};
    end
  end

  assign out_valid = vld[QBITS-1];
  assign out_meta  = meta[QBITS-1];
  assign out_q1    = q1[QBITS-1];
  assign out_q2    = q2[QBITS-1];

endmodule
`default_nettype wire

### src/segment_intersection_test.sv
// Flow: every accepted start transfer gives one done strobe, in the order of the transfers.
// Throughput: one segment pair per cycle; busy stays low outside reset.
// Depth: 7 front stages, 31 divider stages (one quotient bit each), 1 output register.
// Reset: rst is synchronous, active high; it drops all items in flight and sets
// endpoint_epsilon to 66. The receiver cannot stall, so nothing ever backs up.
`default_nettype none
`include "segment_intersection_test_macros.svh"
module segment_intersection_test #(
  parameter int PARAM_FRAC_BITS = 16
) (
  input  wire logic              clk,
  input  wire logic              rst,
  // command channel
  input  wire logic              start,
  input  wire sit_pkg::sit_in_t  operands,
  output logic                   busy,
  output logic                   done,
  output sit_pkg::sit_out_t      result,
  // configuration port
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [2:0]        paddr,
  input  wire logic [31:0]       pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);
  import sit_pkg::*;

  localparam int FRONT_STAGES = 7;
  localparam int LATENCY      = FRONT_STAGES + QBITS + 1;
  localparam int PAR_Q_INT    = PARALLEL_PARAM * (2 ** PARAM_FRAC_BITS);
  localparam logic [31:0] PAR_Q = 32'(PAR_Q_INT);

  logic [EPS_W-1:0] endpoint_epsilon;
  logic             cfg_write;
  logic             accept;

  logic             fr_valid;
  sit_meta_t        fr_meta;
  logic [AD_W-1:0]  fr_ad, fr_r1, fr_r2;
  logic [QBITS-1:0] fr_low1, fr_low2;

  logic             dv_valid;
  sit_meta_t        dv_meta;
  logic [QBITS-1:0] dv_q1, dv_q2;

  sit_out_t         result_next;

  // Hold off new commands only while reset is applied.
  assign busy   = rst;
  assign accept = start && !busy;

  // Single register, decoded wherever paddr[2] is low (addresses 0 to 3); pready is
  // tied high, so an access never waits.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == 1'b0);
  assign prdata    = (paddr[2] == 1'b0) ? 32'(endpoint_epsilon) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      endpoint_epsilon <= EPS_RESET;
    end else if (cfg_write) begin
      endpoint_epsilon <= pwdata[EPS_W-1:0];
    end
  end

  // Front: offsets, cross products, exact in-window test and divider seed.
  sit_front #(
    .FRAC_BITS (PARAM_FRAC_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (accept),
    .operands  (operands),
    .eps       (endpoint_epsilon),
    .out_valid (fr_valid),
    .out_meta  (fr_meta),
    .out_ad    (fr_ad),
    .out_r1    (fr_r1),
    .out_low1  (fr_low1),
    .out_r2    (fr_r2),
    .out_low2  (fr_low2)
  );

  // Divider: both parameters share the determinant as divisor.
  sit_div u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (fr_valid),
    .in_meta   (fr_meta),
    .in_ad     (fr_ad),
    .in_r1     (fr_r1),
    .in_low1   (fr_low1),
    .in_r2     (fr_r2),
    .in_low2   (fr_low2),
    .out_valid (dv_valid),
    .out_meta  (dv_meta),
    .out_q1    (dv_q1),
    .out_q2    (dv_q2)
  );

  // Apply sign and saturation, and override everything for parallel segments.
  always_comb begin
    result_next.is_parallel = dv_meta.par;
    result_next.hit         = dv_meta.hit && !dv_meta.par;
    if (dv_meta.par) begin
      result_next.param_first  = PAR_Q;
      result_next.param_second = PAR_Q;
    end else begin
      if (dv_meta.sat1) begin
        result_next.param_first = dv_meta.neg1 ? SAT_MIN : SAT_MAX;
      end else begin
        result_next.param_first = dv_meta.neg1 ? -{1'b0, dv_q1} : {1'b0, dv_q1};
      end
      if (dv_meta.sat2) begin
        result_next.param_second = dv_meta.neg2 ? SAT_MIN : SAT_MAX;
      end else begin
        result_next.param_second = dv_meta.neg2 ? -{1'b0, dv_q2} : {1'b0, dv_q2};
      end
    end
  end

  // Output register: one strobe per transfer, no back pressure.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= dv_valid;
    end
  end

  always_ff @(posedge clk) begin
    result <= result_next;
  end

  `SIT_ASSERT_NOW(a_done_latency, done, $past(accept, LATENCY), "done without matching start")
  `SIT_ASSERT_NOW(a_parallel_no_hit, done && result.is_parallel, !result.hit, "parallel hit")
  `SIT_ASSERT_NOW(a_hit_nonneg, done && result.hit,
                  !result.param_first[31] && !result.param_second[31], "hit with negative t")
  `SIT_ASSERT_NEXT(a_cfg_write, cfg_write,
                   endpoint_epsilon == $past(pwdata[EPS_W-1:0]), "epsilon write lost")

endmodule
`default_nettype wire

### tb/sit_checker.sv
// Checker for the segment intersection test: predicts each result and compares it.
module sit_checker (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              busy,
  input  sit_pkg::sit_in_t  operands,
  input  logic              done,
  input  sit_pkg::sit_out_t result,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  input  logic              pready,
  output int                fail_count,
  output int                pending
);
  import sit_pkg::*;

  localparam int FRAC = 16;
  localparam logic [2:0] ADDR_EPS = 3'd0;

  logic [EPS_W-1:0] eps_q;
  sit_out_t         expected_results[$];

  assign pending = expected_results.size();

  // Long division of an by ad with fb fraction bits; integer part capped at 2^32.
  function automatic logic [63:0] frac_quotient(input logic [63:0] an, input logic [63:0] ad,
                                                 input int fb, output logic inexact);
    logic [63:0] q;
    logic [63:0] r;
    q = an / ad;
    r = an % ad;
    if (q > 64'h1_0000_0000) q = 64'h1_0000_0000;
    for (int i = 0; i < fb; i++) begin
      r = r << 1;
      q = q << 1;
      if (r >= ad) begin
        r = r - ad;
        q[0] = 1'b1;
      end
    end
    inexact = (r != 0);
    return q;
  endfunction

  function automatic logic [63:0] magnitude(input longint v);
    return v < 0 ? 64'(-v) : 64'(v);
  endfunction

  function automatic logic signed [31:0] param_q(input longint num, input longint det);
    logic        ix;
    logic        neg;
    logic [63:0] q;
    neg = (num < 0) != (det < 0);
    if (num == 0) neg = 1'b0;
    q = frac_quotient(magnitude(num), magnitude(det), FRAC, ix);
    if (q >= 64'h8000_0000) return neg ? SAT_MIN : SAT_MAX;
    return neg ? -q[31:0] : q[31:0];
  endfunction

  function automatic logic within_span(input longint num, input longint det, input logic closed,
                                       input logic [63:0] eps);
    logic [63:0] an;
    logic [63:0] ad;
    logic [63:0] q;
    logic [63:0] top;
    logic        ix;
    an = magnitude(num);
    ad = magnitude(det);
    if (num != 0 && ((num < 0) != (det < 0))) return 1'b0;
    if (an > ad) return 1'b0;
    if (closed) return 1'b1;
    q = frac_quotient(an, ad, EPS_FRAC, ix);
    top = (64'd1 << EPS_FRAC) - eps;
    if (q < eps) return 1'b0;
    if (q > top || (q == top && ix)) return 1'b0;
    return 1'b1;
  endfunction

  function automatic sit_out_t predict_intersection(input sit_in_t a, input logic [EPS_W-1:0] e);
    sit_out_t r;
    longint   det;
    longint   ox;
    longint   oy;
    longint   n1;
    longint   n2;
    det = longint'(a.second_dir_x) * a.first_dir_y - longint'(a.second_dir_y) * a.first_dir_x;
    ox = longint'(a.second_start_x) - a.first_start_x;
    oy = longint'(a.second_start_y) - a.first_start_y;
    if (det == 0) begin
      r.hit = 1'b0;
      r.is_parallel = 1'b1;
      r.param_first = 32'(PARALLEL_PARAM * (1 << FRAC));
      r.param_second = r.param_first;
      return r;
    end
    n1 = longint'(a.second_dir_x) * oy - longint'(a.second_dir_y) * ox;
    n2 = longint'(a.first_dir_x) * oy - longint'(a.first_dir_y) * ox;
    r.hit = within_span(n1, det, a.count_endpoints, 64'(e)) &&
            within_span(n2, det, a.count_endpoints, 64'(e));
    r.is_parallel = 1'b0;
    r.param_first = param_q(n1, det);
    r.param_second = param_q(n2, det);
    return r;
  endfunction

  always @(posedge clk) begin
    sit_out_t want;
    if (rst) begin
      eps_q <= EPS_RESET;
      expected_results.delete();
      fail_count <= 0;
    end else begin
      if (done) begin
        if (expected_results.size() == 0) begin
          if (fail_count < 10) $display("unexpected result %p", result);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_results.pop_front();
          if (want !== result) begin
            if (fail_count < 10) $display("mismatch: expected %p, got %p", want, result);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (start && !busy) expected_results.push_back(predict_intersection(operands, eps_q));
      if (psel && penable && pwrite && pready && paddr == ADDR_EPS) eps_q <= pwdata[EPS_W-1:0];
    end
  end
endmodule

### tb/tb.sv
// Testbench top for the segment intersection test: stimulus, config writes, verdict.
module tb;
  import sit_pkg::*;

  localparam int LATENCY = 39;
  localparam int LIMIT = 400000;
  localparam int IN_W = $bits(sit_in_t);
  localparam logic [2:0] ADDR_EPS = 3'd0;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  sit_in_t     operands = '0;
  logic        busy;
  logic        done;
  sit_out_t    result;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  int          fail_count;
  int          pending;
  int          cycle_count = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  segment_intersection_test i_dut (
    .clk, .rst, .start, .operands, .busy, .done, .result,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  sit_checker i_checker (
    .clk, .rst, .start, .busy, .operands, .done, .result,
    .psel, .penable, .pwrite, .paddr, .pwdata, .pready, .fail_count, .pending
  );

  // Hard stop in case the block hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Setup cycle then access cycle; the write lands on the access edge.
  task automatic write_epsilon(input logic [14:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_EPS;
    pwdata <= 32'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // Hold the sender until every expected result has arrived, then let the pipe drain.
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  // Present one item and hold it until the transfer happens.
  task automatic send_pair(input sit_in_t item);
    start <= 1'b1;
    operands <= item;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic maybe_gap(input bit allow);
    if (allow && $urandom_range(0, 5) == 0) begin
      start <= 1'b0;
      operands <= sit_in_t'(IN_W'({$urandom, $urandom, $urandom, $urandom, $urandom}));
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  function automatic logic [15:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'($signed($urandom_range(0, 40)) - 20);
      3: return 16'($signed($urandom_range(0, 2000)) - 1000);
      default: return 16'($urandom);
    endcase
  endfunction

  // Mostly build crossings by placing the second segment through a chosen point
  // on the first; the rest is raw noise, parallel or degenerate pairs and extreme values.
  function automatic sit_in_t random_pair();
    sit_in_t p;
    int      k;
    p = sit_in_t'(IN_W'({$urandom, $urandom, $urandom, $urandom, $urandom}));
    k = $urandom_range(0, 9);
    if (k < 6) begin
      p.first_start_x = 16'($signed($urandom_range(0, 2000)) - 1000);
      p.first_start_y = 16'($signed($urandom_range(0, 2000)) - 1000);
      p.first_dir_x = 16'($signed($urandom_range(0, 400)) - 200);
      p.first_dir_y = 16'($signed($urandom_range(0, 400)) - 200);
      p.second_dir_x = 16'($signed($urandom_range(0, 400)) - 200);
      p.second_dir_y = 16'($signed($urandom_range(0, 400)) - 200);
      p.second_start_x = p.first_start_x + p.first_dir_x / 2 - p.second_dir_x / 2;
      p.second_start_y = p.first_start_y + p.first_dir_y / 2 - p.second_dir_y / 2;
      if ($urandom_range(0, 2) == 0) begin
        p.second_start_x = p.first_start_x + p.first_dir_x;
        p.second_start_y = p.first_start_y + p.first_dir_y;
      end
    end else if (k == 6) begin
      p.second_dir_x = p.first_dir_x * 2;
      p.second_dir_y = p.first_dir_y * 2;
      p.first_dir_x[15] = 1'b0;
      p.first_dir_y[15] = 1'b0;
      p.second_dir_x = p.first_dir_x;
      p.second_dir_y = p.first_dir_y;
    end else if (k == 7) begin
      p.first_start_x = rand_coord();
      p.first_start_y = rand_coord();
      p.first_dir_x = rand_coord();
      p.first_dir_y = rand_coord();
      p.second_start_x = rand_coord();
      p.second_start_y = rand_coord();
      p.second_dir_x = rand_coord();
      p.second_dir_y = rand_coord();
    end
    return p;
  endfunction

  function automatic sit_in_t make_pair(input int sx1, sy1, dx1, dy1, sx2, sy2, dx2, dy2,
                                        input logic ends);
    sit_in_t p;
    p.first_start_x = 16'(sx1);
    p.first_start_y = 16'(sy1);
    p.first_dir_x = 16'(dx1);
    p.first_dir_y = 16'(dy1);
    p.second_start_x = 16'(sx2);
    p.second_start_y = 16'(sy2);
    p.second_dir_x = 16'(dx2);
    p.second_dir_y = 16'(dy2);
    p.count_endpoints = ends;
    return p;
  endfunction

  initial begin
    logic [14:0] eps_settings [4];
    eps_settings = '{15'd0, 15'h7FFF, 15'd1, 15'd16384};
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: cross, endpoint touch both ways, parallel, degenerate, saturation, extremes.
    for (int e = 0; e < 2; e++) begin
      send_pair(make_pair(0, 0, 10, 10, 0, 10, 10, -10, e));
      send_pair(make_pair(0, 0, 10, 0, 10, 0, 0, 10, e));
      send_pair(make_pair(0, 0, 10, 0, 0, 0, 0, 10, e));
      send_pair(make_pair(0, 0, 10, 10, 5, 0, 20, 20, e));
      send_pair(make_pair(0, 0, 0, 0, 1, 1, 3, 4, e));
      send_pair(make_pair(0, 0, 1, 0, 32767, -32768, 0, 1, e));
      send_pair(make_pair(-32768, -32768, 1, 0, 32767, 32767, 0, -1, e));
      send_pair(make_pair(-32768, 32767, -32768, -32768, 32767, -32768, 32767, 32767, e));
      send_pair(make_pair(32767, 32767, 32767, -32768, -32768, 32767, -32768, -32768, e));
      send_pair(make_pair(0, 0, 65536, 1, 0, 0, 1, 65536, e));
      send_pair(make_pair(0, 0, 100, 0, 99, -5, 0, 10, e));
      send_pair(make_pair(0, 0, 3, 0, 1, -1, 0, 2, e));
    end
    drain();

    // Sweep epsilon settings, extremes included; random traffic under each.
    for (int ph = 0; ph < 5; ph++) begin
      if (ph < 4) write_epsilon(eps_settings[ph]);
      else write_epsilon(15'($urandom_range(0, 600)));
      for (int i = 0; i < 240; i++) begin
        maybe_gap(!(ph == 4 && i > 150));
        send_pair(random_pair());
      end
      drain();
    end

    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
